// ===== rtl/seg_isect_pkg.sv =====
// seg_isect_pkg: shared codes for the segment intersection core
// no dependencies
package seg_isect_pkg;

    // configuration register indexes
    localparam logic REG_DET_THR   = 1'b0;
    localparam logic REG_PARAM_TOL = 1'b1;

    localparam int unsigned CFG_DATA_BITS = 32;
    localparam int unsigned TOL_BITS      = 16;

    // result codes
    typedef enum logic [1:0] {
        OUTCOME_MEET     = 2'd0,
        OUTCOME_PARALLEL = 2'd1,
        OUTCOME_OUTSIDE  = 2'd2
    } outcome_t;

endpackage

// ===== rtl/segment_intersection_core.sv =====
// segment_intersection_core: pipelined 2-D segment intersection test
// depends on seg_isect_pkg
//
// usage
// - input channel s_*: one request holds two segments (end point and direction,
//   signed fixed point with 8 fraction bits), taken when s_valid and s_ready
// - result channel m_*: one result per request, in order: outcome code and the
//   crossing point (zero unless the segments meet)
// - configuration: cfg_wr_en/cfg_index/cfg_wdata write the parallel threshold
//   (index 0) and the parameter slack (index 1); write only while idle
// - pipeline: PARAM_FRAC_BITS + 10 register stages, the number set by the
//   one-bit-per-stage restoring dividers for s and t
// - throughput: one request per cycle unless the receiver stalls; all stages advance together
// - when the receiver stalls the whole pipeline holds, s_ready drops, and no
//   request is lost or repeated
// - reset (aresetn low, synchronous) empties the pipeline and loads the
//   register defaults: threshold 0, slack 16
module segment_intersection_core
    import seg_isect_pkg::*;
#(
    parameter int COORD_BITS      = 24,
    parameter int PARAM_FRAC_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_wr_en,
    input  logic                            cfg_index,
    input  logic [CFG_DATA_BITS-1:0]        cfg_wdata,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [COORD_BITS-1:0]    s_v_end_x,
    input  logic signed [COORD_BITS-1:0]    s_v_end_y,
    input  logic signed [COORD_BITS-1:0]    s_v_dir_x,
    input  logic signed [COORD_BITS-1:0]    s_v_dir_y,
    input  logic signed [COORD_BITS-1:0]    s_w_end_x,
    input  logic signed [COORD_BITS-1:0]    s_w_end_y,
    input  logic signed [COORD_BITS-1:0]    s_w_dir_x,
    input  logic signed [COORD_BITS-1:0]    s_w_dir_y,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_outcome,
    output logic signed [COORD_BITS-1:0]    m_cross_x,
    output logic signed [COORD_BITS-1:0]    m_cross_y
);

    localparam int C   = COORD_BITS;
    localparam int F   = PARAM_FRAC_BITS;
    localparam int KW  = C + 1;          // end point difference
    localparam int PW  = C + KW;         // product with a difference
    localparam int NW  = 2 * C + 2;      // det and numerators
    localparam int XW  = NW + 3;         // divider remainder
    localparam int QW  = F + 2;          // quotient bits below 4.0
    localparam int TW  = F + 4;          // signed parameter
    localparam int CW  = (NW > CFG_DATA_BITS) ? NW : CFG_DATA_BITS;
    localparam int EW  = ((TW > TOL_BITS + 2) ? TW : TOL_BITS + 2) + 1;
    localparam int PRW = TW + C;         // parameter times direction
    localparam int OW  = PRW - F;        // rounded offset
    localparam int DFW = OW + 1;
    localparam int NV  = QW + 8;         // pipeline depth

    localparam logic signed [EW-1:0]  PARAM_ONE = EW'(64'd1 << F);
    localparam logic signed [PRW-1:0] HALF_LSB  = PRW'(64'd1 << (F - 1));
    localparam logic signed [DFW-1:0] COORD_MAX = DFW'((64'd1 << (C - 1)) - 64'd1);
    localparam logic signed [DFW-1:0] COORD_MIN = -COORD_MAX - DFW'(1);

    typedef struct packed {
        logic                   par;
        logic                   neg_s;
        logic                   neg_t;
        logic signed [C-1:0]    wex;
        logic signed [C-1:0]    wey;
        logic signed [C-1:0]    wdx;
        logic signed [C-1:0]    wdy;
    } side_t;

    // configuration registers
    logic [CFG_DATA_BITS-1:0] det_thr_reg;
    logic [TOL_BITS-1:0]      tol_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            det_thr_reg <= '0;
            tol_reg     <= TOL_BITS'(16);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DET_THR:   det_thr_reg <= cfg_wdata;
                REG_PARAM_TOL: tol_reg     <= cfg_wdata[TOL_BITS-1:0];
                default: ;
            endcase
        end
    end

    // global advance
    logic          en;
    logic [NV-1:0] vld_reg;

    assign m_valid = vld_reg[NV-1];
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NV-2:0], s_valid};
        end
    end

    // stage 0: differences of end points
    logic signed [C-1:0]  s0_vdx_reg, s0_vdy_reg;
    logic signed [KW-1:0] s0_kx_reg, s0_ky_reg;
    side_t                s0_side_reg;
    side_t                s0_side_next;

    always_comb begin
        s0_side_next     = '0;
        s0_side_next.wex = s_w_end_x;
        s0_side_next.wey = s_w_end_y;
        s0_side_next.wdx = s_w_dir_x;
        s0_side_next.wdy = s_w_dir_y;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_vdx_reg  <= s_v_dir_x;
            s0_vdy_reg  <= s_v_dir_y;
            s0_kx_reg   <= KW'(s_w_end_x) - KW'(s_v_end_x);
            s0_ky_reg   <= KW'(s_w_end_y) - KW'(s_v_end_y);
            s0_side_reg <= s0_side_next;
        end
    end

    // stage 1: cross products
    logic signed [PW-1:0] s1_pa_reg, s1_pb_reg, s1_pc_reg, s1_pd_reg, s1_pe_reg, s1_pf_reg;
    side_t                s1_side_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_pa_reg   <= PW'(s0_side_reg.wdx) * PW'(s0_vdy_reg);
            s1_pb_reg   <= PW'(s0_side_reg.wdy) * PW'(s0_vdx_reg);
            s1_pc_reg   <= PW'(s0_side_reg.wdy) * PW'(s0_kx_reg);
            s1_pd_reg   <= PW'(s0_side_reg.wdx) * PW'(s0_ky_reg);
            s1_pe_reg   <= PW'(s0_vdy_reg) * PW'(s0_kx_reg);
            s1_pf_reg   <= PW'(s0_vdx_reg) * PW'(s0_ky_reg);
            s1_side_reg <= s0_side_reg;
        end
    end

    // stage 2: determinant and numerators
    logic signed [NW-1:0] s2_det_reg, s2_ns_reg, s2_nt_reg;
    side_t                s2_side_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_det_reg  <= NW'(s1_pa_reg) - NW'(s1_pb_reg);
            s2_ns_reg   <= NW'(s1_pc_reg) - NW'(s1_pd_reg);
            s2_nt_reg   <= NW'(s1_pe_reg) - NW'(s1_pf_reg);
            s2_side_reg <= s1_side_reg;
        end
    end

    // stage 3: magnitudes, signs, parallel test
    logic [NW-1:0] s3_adet_reg, s3_ms_reg, s3_mt_reg;
    side_t         s3_side_reg;
    logic [NW-1:0] adet_next;
    side_t         s3_side_next;

    assign adet_next = s2_det_reg[NW-1] ? NW'(-s2_det_reg) : NW'(s2_det_reg);

    always_comb begin
        s3_side_next       = s2_side_reg;
        s3_side_next.par   = (CW'(adet_next) <= CW'(det_thr_reg));
        s3_side_next.neg_s = s2_ns_reg[NW-1] ^ s2_det_reg[NW-1];
        s3_side_next.neg_t = s2_nt_reg[NW-1] ^ s2_det_reg[NW-1];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_adet_reg <= adet_next;
            s3_ms_reg   <= s2_ns_reg[NW-1] ? NW'(-s2_ns_reg) : NW'(s2_ns_reg);
            s3_mt_reg   <= s2_nt_reg[NW-1] ? NW'(-s2_nt_reg) : NW'(s2_nt_reg);
            s3_side_reg <= s3_side_next;
        end
    end

    // divider: remainder kept below 4*det, one quotient bit per stage
    logic [XW-1:0] dv_d4_reg  [0:QW];
    logic [XW-1:0] dv_rs_reg  [0:QW];
    logic [XW-1:0] dv_rt_reg  [0:QW];
    logic [QW-1:0] dv_qs_reg  [0:QW];
    logic [QW-1:0] dv_qt_reg  [0:QW];
    logic          dv_sats_reg[0:QW];
    logic          dv_satt_reg[0:QW];
    side_t         dv_side_reg[0:QW];

    logic [XW-1:0] d4_next;
    assign d4_next = {1'b0, s3_adet_reg, 2'b00};

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_d4_reg[0]   <= d4_next;
            dv_rs_reg[0]   <= XW'(s3_ms_reg);
            dv_rt_reg[0]   <= XW'(s3_mt_reg);
            dv_qs_reg[0]   <= '0;
            dv_qt_reg[0]   <= '0;
            dv_sats_reg[0] <= (XW'(s3_ms_reg) >= d4_next);
            dv_satt_reg[0] <= (XW'(s3_mt_reg) >= d4_next);
            dv_side_reg[0] <= s3_side_reg;
        end
    end

    for (genvar j = 1; j <= QW; j++) begin : g_div
        logic [XW-1:0] xs, xt;
        logic          bs, bt;

        assign xs = {dv_rs_reg[j-1][XW-2:0], 1'b0};
        assign xt = {dv_rt_reg[j-1][XW-2:0], 1'b0};
        assign bs = xs >= dv_d4_reg[j-1];
        assign bt = xt >= dv_d4_reg[j-1];

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_d4_reg[j]   <= dv_d4_reg[j-1];
                dv_rs_reg[j]   <= bs ? xs - dv_d4_reg[j-1] : xs;
                dv_rt_reg[j]   <= bt ? xt - dv_d4_reg[j-1] : xt;
                dv_qs_reg[j]   <= {dv_qs_reg[j-1][QW-2:0], bs};
                dv_qt_reg[j]   <= {dv_qt_reg[j-1][QW-2:0], bt};
                dv_sats_reg[j] <= dv_sats_reg[j-1];
                dv_satt_reg[j] <= dv_satt_reg[j-1];
                dv_side_reg[j] <= dv_side_reg[j-1];
            end
        end
    end

    // stage 5: saturate at 4.0 and apply sign
    logic signed [TW-1:0] s5_s_reg, s5_t_reg;
    side_t                s5_side_reg;
    logic [TW-1:0]        qs_mag, qt_mag;

    assign qs_mag = dv_sats_reg[QW] ? TW'(64'd4 << F) : TW'(dv_qs_reg[QW]);
    assign qt_mag = dv_satt_reg[QW] ? TW'(64'd4 << F) : TW'(dv_qt_reg[QW]);

    always_ff @(posedge aclk) begin
        if (en) begin
            s5_s_reg    <= dv_side_reg[QW].neg_s ? -$signed(qs_mag) : $signed(qs_mag);
            s5_t_reg    <= dv_side_reg[QW].neg_t ? -$signed(qt_mag) : $signed(qt_mag);
            s5_side_reg <= dv_side_reg[QW];
        end
    end

    // stage 6: interval test and offset products
    logic                  s6_in_reg;
    logic signed [PRW-1:0] s6_px_reg, s6_py_reg;
    side_t                 s6_side_reg;
    logic signed [EW-1:0]  tol_s, lo_s, hi_s, se, te;

    assign tol_s = EW'($signed({1'b0, tol_reg}));
    assign lo_s  = -tol_s;
    assign hi_s  = PARAM_ONE + tol_s;
    assign se    = EW'(s5_s_reg);
    assign te    = EW'(s5_t_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            s6_in_reg   <= (se > lo_s) && (se < hi_s) && (te > lo_s) && (te < hi_s);
            s6_px_reg   <= PRW'(s5_t_reg) * PRW'(s5_side_reg.wdx);
            s6_py_reg   <= PRW'(s5_t_reg) * PRW'(s5_side_reg.wdy);
            s6_side_reg <= s5_side_reg;
        end
    end

    // stage 7: round, subtract, saturate into the output register
    logic signed [PRW-1:0] rx, ry;
    logic signed [DFW-1:0] dx, dy;
    logic signed [C-1:0]   cx, cy;
    logic [1:0]            out_reg;
    logic signed [C-1:0]   cross_x_reg, cross_y_reg;

    assign rx = (s6_px_reg + HALF_LSB) >>> F;
    assign ry = (s6_py_reg + HALF_LSB) >>> F;
    assign dx = DFW'(s6_side_reg.wex) - DFW'($signed(rx[OW-1:0]));
    assign dy = DFW'(s6_side_reg.wey) - DFW'($signed(ry[OW-1:0]));

    always_comb begin
        priority if (dx > COORD_MAX) cx = C'(COORD_MAX);
        else if (dx < COORD_MIN)     cx = C'(COORD_MIN);
        else                         cx = C'(dx);
        priority if (dy > COORD_MAX) cy = C'(COORD_MAX);
        else if (dy < COORD_MIN)     cy = C'(COORD_MIN);
        else                         cy = C'(dy);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            priority if (s6_side_reg.par) begin
                out_reg     <= OUTCOME_PARALLEL;
                cross_x_reg <= '0;
                cross_y_reg <= '0;
            end else if (s6_in_reg) begin
                out_reg     <= OUTCOME_MEET;
                cross_x_reg <= cx;
                cross_y_reg <= cy;
            end else begin
                out_reg     <= OUTCOME_OUTSIDE;
                cross_x_reg <= '0;
                cross_y_reg <= '0;
            end
        end
    end

    assign m_outcome = out_reg;
    assign m_cross_x = cross_x_reg;
    assign m_cross_y = cross_y_reg;

endmodule
